[rtl/core/nat_pkg.sv]
// Package for the node address table: field widths, operation codes and the
// scan sequencer state type. No dependencies.
`default_nettype none

package nat_pkg;

   localparam int KEY_W  = 64;
   localparam int ADDR_W = 16;
   localparam int SLOT_W = KEY_W + ADDR_W;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_REMOVE = 2'd1;
   localparam mode_type MODE_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

[rtl/core/node_address_table.sv]
// Node address table top level: request register, slot scan sequencer,
// per-slot valid bits and result register. Uses nat_pkg and nat_ram.
`default_nettype none

// Usage
// -----
// The table maps a 64-bit device identifier to a 16-bit short address. A
// request is taken at a rising edge where start is high and busy is low. It
// carries a mode (insert, remove or lookup), the long key and, for insert,
// the short address to store.
// Every request produces exactly one response, shown on the rsp_ ports for a
// single cycle with rsp_valid high. The receiver cannot stall, so the
// response must be captured in that cycle.
// Each request walks every slot once through the single read port of the
// slot memory, one slot per cycle. The response appears once the last
// slot's compare is registered, and busy drops in that same cycle, so a
// new request can be taken at its end; the table takes no new request
// until it has answered the last one.
// Insert fills the lowest empty slot (key of zero) and flags table_full if
// there is none. Remove clears every matching slot. Lookup returns the
// address of the lowest matching slot, with found high when one matched.
// Reset clears the valid bit of every slot at once; a slot that is not
// valid reads as an empty slot with address zero, so no clearing pass runs.
module node_address_table #(
   parameter int ENTRIES = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire nat_pkg::mode_type         req_mode,
   input  wire logic [nat_pkg::KEY_W-1:0] req_long_key,
   input  wire logic [nat_pkg::ADDR_W-1:0] req_short_addr_in,
   output logic                           rsp_valid,
   output logic [nat_pkg::ADDR_W-1:0]     rsp_short_addr_out,
   output logic                           rsp_found,
   output logic                           rsp_table_full
);

   import nat_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   // Sequencer state.
   state_type state_ff, state_in;

   // Latched request.
   mode_type          mode_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Read issue and compare stage.
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] cmp_idx_ff;
   logic          cmp_vld_ff;

   // Scan accumulators.
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] acc_addr_ff, acc_addr_in;

   // Valid bit per slot.
   logic [ENTRIES-1:0] valid_ff, valid_in;

   // Response register.
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_full_ff, rsp_full_in;

   // Decoded sequencer outputs.
   logic accept;
   logic issue;
   logic finish;

   // Memory ports.
   logic              wr_en;
   logic [SLOT_W-1:0] wr_data;
   logic [SLOT_W-1:0] rd_data;

   // Current slot as seen through its valid bit.
   logic [KEY_W-1:0]  slot_key;
   logic [ADDR_W-1:0] slot_addr;
   logic              slot_match;
   logic              slot_empty;

   nat_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmp_idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy   = 1'b1;
      issue  = 1'b0;
      finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SCAN: begin
            issue = 1'b1;
         end
         ST_DRAIN: begin
            finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign accept = start && !busy;

   // A slot without its valid bit is empty with a zero address.
   assign slot_key   = valid_ff[cmp_idx_ff] ? rd_data[SLOT_W-1:ADDR_W] : '0;
   assign slot_addr  = valid_ff[cmp_idx_ff] ? rd_data[ADDR_W-1:0] : '0;
   assign slot_match = (slot_key == key_ff);
   assign slot_empty = (slot_key == '0);
   assign wr_data    = {key_ff, addr_ff};

   // Compare stage: act on the slot whose read data just returned. Insert and
   // lookup only act on the first qualifying slot; remove acts on all.
   always_comb begin
      wr_en       = 1'b0;
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      acc_addr_in = acc_addr_ff;
      rd_idx_in   = rd_idx_ff;

      if (accept) begin
         hit_in      = 1'b0;
         acc_addr_in = '0;
         rd_idx_in   = '0;
      end else if (issue && rd_idx_ff != LAST_IDX) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      if (cmp_vld_ff) begin
         case (mode_ff)
            MODE_INSERT: begin
               if (slot_empty && !hit_ff) begin
                  wr_en                = 1'b1;
                  valid_in[cmp_idx_ff] = 1'b1;
                  hit_in               = 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (slot_match) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  hit_in               = 1'b1;
               end
            end
            MODE_LOOKUP: begin
               if (slot_match && !hit_ff) begin
                  acc_addr_in = slot_addr;
                  hit_in      = 1'b1;
               end
            end
            default: begin
               hit_in = hit_ff;
            end
         endcase
      end
   end

   // Response formed from the accumulators after the last slot's compare.
   always_comb begin
      rsp_addr_in  = '0;
      rsp_found_in = 1'b0;
      rsp_full_in  = 1'b0;
      case (mode_ff)
         MODE_INSERT: begin
            rsp_full_in = !hit_in;
         end
         MODE_REMOVE: begin
            rsp_found_in = hit_in;
         end
         MODE_LOOKUP: begin
            rsp_addr_in  = acc_addr_in;
            rsp_found_in = hit_in;
         end
         default: begin
            rsp_addr_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= issue;
         valid_ff     <= valid_in;
         rsp_valid_ff <= finish;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_long_key;
         addr_ff <= req_short_addr_in;
      end
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= rd_idx_ff;
      hit_ff      <= hit_in;
      acc_addr_ff <= acc_addr_in;
      if (finish) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_found_ff <= rsp_found_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_short_addr_out = rsp_addr_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_table_full     = rsp_full_ff;

`ifndef SYNTHESIS
   // The response comes only once the scan is over.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while a scan is running");

   // The final compare always yields a response in the next cycle.
   a_drain_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid)
      else $error("scan finished without a response");

   // A dropped insert means every slot holds a valid entry.
   a_full_all_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (&valid_ff))
      else $error("table_full reported with a free slot");

   // Found and table_full belong to different operations.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_table_full))
      else $error("found and table_full both set");
`endif

endmodule

`default_nettype wire

[rtl/core/nat_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No dependencies.
`default_nettype none

module nat_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[verif/tb_node_address_table.sv]
// Self-checking testbench for the node address table: directed requests, then
// random phases of insert, remove and lookup traffic against a shadow table.
// Depends on nat_pkg and the node_address_table RTL.
`timescale 1ns / 100ps

module tb_node_address_table;

   import nat_pkg::*;

   localparam int ENTRIES = 16;
   // The block ignores mode 3, so the package has no name for it.
   localparam mode_type MODE_UNUSED = 2'd3;
   // Cycles without a handshake or a response before the run is declared hung.
   localparam int HANG_LIMIT = 500;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int KEY_POOL_SIZE = 24;
   localparam int DIRECTED_ROWS = 14;
   localparam logic [KEY_W-1:0] ALL_ONES_KEY = '1;

   typedef struct packed {
      logic [ADDR_W-1:0] short_addr;
      logic              found;
      logic              table_full;
   } table_reply_t;

   typedef struct {
      mode_type          mode;
      logic [KEY_W-1:0]  long_key;
      logic [ADDR_W-1:0] short_addr;
      bit                typed;
      table_reply_t      reply;
   } stim_row_t;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   mode_type             req_mode;
   logic [KEY_W-1:0]     req_long_key;
   logic [ADDR_W-1:0]    req_short_addr_in;
   logic                 rsp_valid;
   logic [ADDR_W-1:0]    rsp_short_addr_out;
   logic                 rsp_found;
   logic                 rsp_table_full;

   // Shadow copy of the slot memory, updated in acceptance order.
   logic [KEY_W-1:0]     shadow_keys  [ENTRIES];
   logic [ADDR_W-1:0]    shadow_addrs [ENTRIES];
   table_reply_t         pending_replies [$];
   logic [KEY_W-1:0]     key_pool [KEY_POOL_SIZE];

   int                   error_count;
   int                   idle_cycles;
   int                   mode_counts [4];
   int                   full_count;
   int                   hit_count;

   // Directed requests. A typed reply is used where it follows directly from
   // the table contents; other rows are checked against the shadow table.
   stim_row_t directed_rows [DIRECTED_ROWS] = '{
      // Right after reset every slot is empty, so a zero key matches slot 0.
      '{MODE_LOOKUP, 64'h0,             16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b0}},
      '{MODE_LOOKUP, ALL_ONES_KEY,      16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_INSERT, ALL_ONES_KEY,      16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_LOOKUP, ALL_ONES_KEY,      16'h0000, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
      '{MODE_UNUSED, ALL_ONES_KEY,      16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_INSERT, 64'h1,             16'h0001, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      // A zero key lands in the lowest empty slot, which stays empty.
      '{MODE_INSERT, 64'h0,             16'hABCD, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_LOOKUP, 64'h0,             16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
      // A duplicate key takes the lowest empty slot, slot 2; lookup still
      // sees slot 0.
      '{MODE_INSERT, ALL_ONES_KEY,      16'h1234, 1'b0, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_LOOKUP, ALL_ONES_KEY,      16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
      // Remove clears both copies of the duplicate key.
      '{MODE_REMOVE, ALL_ONES_KEY,      16'h5555, 1'b0, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_LOOKUP, ALL_ONES_KEY,      16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      // Removing the zero key clears the address of every empty slot.
      '{MODE_REMOVE, 64'h0,             16'h0000, 1'b0, '{16'h0000, 1'b0, 1'b0}},
      '{MODE_UNUSED, 64'h0,             16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}}
   };

   node_address_table #(
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_long_key      (req_long_key),
      .req_short_addr_in (req_short_addr_in),
      .rsp_valid         (rsp_valid),
      .rsp_short_addr_out(rsp_short_addr_out),
      .rsp_found         (rsp_found),
      .rsp_table_full    (rsp_table_full)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Computes the reply the table gives to one request and applies the
   // request to the shadow table, slot by slot from the lowest.
   function automatic table_reply_t predict_table_reply(mode_type mode,
                                                        logic [KEY_W-1:0] long_key,
                                                        logic [ADDR_W-1:0] short_addr);
      table_reply_t reply;
      bit           done;
      reply = '0;
      done  = 1'b0;
      case (mode)
         MODE_INSERT: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!done && shadow_keys[i] == '0) begin
                  shadow_keys[i]  = long_key;
                  shadow_addrs[i] = short_addr;
                  done = 1'b1;
               end
            end
            reply.table_full = !done;
         end
         MODE_REMOVE: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (shadow_keys[i] == long_key) begin
                  shadow_keys[i]  = '0;
                  shadow_addrs[i] = '0;
                  reply.found = 1'b1;
               end
            end
         end
         MODE_LOOKUP: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!done && shadow_keys[i] == long_key) begin
                  reply.short_addr = shadow_addrs[i];
                  reply.found = 1'b1;
                  done = 1'b1;
               end
            end
         end
         default: begin
            // The unused mode leaves the table alone and replies all zeros.
         end
      endcase
      return reply;
   endfunction

   // Presents one request at the falling edge and holds it until the rising
   // edge where busy is low. The expected reply is queued at that edge, so
   // the queue stays in the order in which the block takes requests. Start is
   // left high; the caller either presents the next request or pauses.
   task automatic issue_request(mode_type mode, logic [KEY_W-1:0] long_key,
                                logic [ADDR_W-1:0] short_addr, bit typed,
                                table_reply_t typed_reply, output table_reply_t reply);
      @(negedge clock);
      start             = 1'b1;
      req_mode          = mode;
      req_long_key      = long_key;
      req_short_addr_in = short_addr;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      reply = predict_table_reply(mode, long_key, short_addr);
      if (reply.table_full) full_count++;
      if (reply.found) hit_count++;
      mode_counts[mode]++;
      if (typed) reply = typed_reply;
      pending_replies.push_back(reply);
   endtask

   // Drops start for a number of cycles between bursts of requests.
   task automatic pause_sender(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Mostly keys from a small pool, so that inserts, removes and lookups hit
   // the same slots; the rest are the zero key, all ones and fresh keys.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      if (roll < 78) return '0;
      if (roll < 83) return ALL_ONES_KEY;
      return {$urandom, $urandom};
   endfunction

   // Response checker. The receiver cannot stall, so every strobe is taken.
   always @(posedge clock) begin
      table_reply_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $error("Response with no request outstanding: short_addr_out %h found %b full %b",
                   rsp_short_addr_out, rsp_found, rsp_table_full);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_short_addr_out !== want.short_addr) begin
               $error("short_addr_out: expected %h, actual %h",
                      want.short_addr, rsp_short_addr_out);
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %b, actual %b", want.found, rsp_found);
               error_count++;
            end
            if (rsp_table_full !== want.table_full) begin
               $error("table_full: expected %b, actual %b", want.table_full,
                      rsp_table_full);
               error_count++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a handshake.", HANG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      table_reply_t reply;
      int           issued;
      int           phase_left;
      int           insert_pct;
      int           burst_left;
      int           roll;
      mode_type     mode;
      logic [KEY_W-1:0] long_key;

      // Every input is known from time zero.
      reset             = 1'b1;
      start             = 1'b0;
      req_mode          = MODE_LOOKUP;
      req_long_key      = '0;
      req_short_addr_in = '0;
      full_count        = 0;
      hit_count         = 0;
      foreach (mode_counts[i]) mode_counts[i] = 0;
      foreach (shadow_keys[i]) begin
         shadow_keys[i]  = '0;
         shadow_addrs[i] = '0;
      end
      // The pool holds random keys plus the single-bit extremes.
      foreach (key_pool[i]) begin
         key_pool[i] = {$urandom, $urandom};
         if (key_pool[i] == '0) key_pool[i] = 64'h1;
      end
      key_pool[0] = 64'h1;
      key_pool[1] = 64'h8000_0000_0000_0000;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, walked row by row.
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].mode, directed_rows[i].long_key,
                       directed_rows[i].short_addr, directed_rows[i].typed,
                       directed_rows[i].reply, reply);
      end

      // The random part opens by filling the table with fresh keys until an
      // insert is dropped, then looks up the zero key, which now misses.
      do begin
         issue_request(MODE_INSERT, {$urandom, $urandom} | 64'h1, 16'($urandom),
                       1'b0, '0, reply);
      end while (!reply.table_full);
      issue_request(MODE_LOOKUP, '0, '0, 1'b1, '0, reply);

      // Random phases. Each phase has its own insert rate, so the table swings
      // between nearly empty and full. The sender works in bursts with gaps.
      issued     = 0;
      phase_left = 0;
      insert_pct = 50;
      burst_left = $urandom_range(1, 30);
      while (issued < RANDOM_REQUESTS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(40, 160);
            case ($urandom_range(3))
               0: insert_pct = 15;
               1: insert_pct = 40;
               2: insert_pct = 65;
               default: insert_pct = 90;
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 3) begin
            mode = MODE_UNUSED;
         end else if (roll < 3 + insert_pct) begin
            mode = MODE_INSERT;
         end else if ($urandom_range(2) == 0) begin
            mode = MODE_REMOVE;
         end else begin
            mode = MODE_LOOKUP;
         end
         long_key = pick_key();
         issue_request(mode, long_key, 16'($urandom), 1'b0, '0, reply);
         if (mode != MODE_UNUSED) issued++;
         phase_left--;
         burst_left--;
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 12));
            // Now and then a long burst with no gaps at all.
            burst_left = ($urandom_range(3) == 0) ? 100 : $urandom_range(1, 30);
         end
      end
      @(negedge clock);
      start = 1'b0;

      // Drain the outstanding replies, then watch a while for stray strobes.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4 * (ENTRIES + 2)) @(posedge clock);

      $display("Covered %0d inserts, %0d removes, %0d lookups and %0d unused-mode requests;",
               mode_counts[MODE_INSERT], mode_counts[MODE_REMOVE],
               mode_counts[MODE_LOOKUP], mode_counts[MODE_UNUSED]);
      $display("%0d inserts hit a full table and %0d removes or lookups found a match.",
               full_count, hit_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
